[src/assert_macros.svh]
// Assertion macros for the checker file of the blur block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, off while reset is high.
`define BB3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Concurrent check that also holds across reset.
`define BB3_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

`endif

[src/bb3_pkg.sv]
// Package with constants, types and the reciprocal table of the blur block.
package bb3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WCFG_W      = 11;
  localparam int HCFG_W      = 13;
  localparam int CH_W        = 8;
  localparam int NCH         = 3;
  localparam int PIX_W       = CH_W * NCH;
  localparam int NWIN        = 9;
  localparam int CNT_W       = 4;
  localparam int SUM_W       = 12;
  localparam int SUM_X_W     = 13;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = SUM_X_W + RECIP_W;

  // Register indexes on the configuration port
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX,
    ST_DR1,
    ST_DR2,
    ST_DR3,
    ST_GO,
    ST_WAIT,
    ST_CAP,
    ST_OUT
  } state_t;

  typedef logic [NWIN-1:0][CH_W-1:0] lane_win_t;

  typedef struct packed {
    logic [NWIN-1:0]  mask;
    logic [CNT_W-1:0] cnt;
  } lane_ctl_t;

  // ceil(2^20 / (2*n)) for the neighbor counts that occur
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd6:    r = 20'd87382;
      4'd9:    r = 20'd58255;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

endpackage

[src/bb3_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bb3_lane.sv]
// One color lane: masked window sum and rounded mean by reciprocal multiply.
module bb3_lane (
  input  logic                    clk,
  input  bb3_pkg::lane_win_t      win,
  input  bb3_pkg::lane_ctl_t      ctl,
  output logic [bb3_pkg::CH_W-1:0] mean
);
  import bb3_pkg::*;

  logic [SUM_W-1:0]   sum;
  logic [SUM_X_W-1:0] x;
  logic [RECIP_W-1:0] rcp;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    sum = '0;
    for (int k = 0; k < NWIN; k++) begin
      if (ctl.mask[k]) begin
        sum = sum + SUM_W'(win[k]);
      end
    end
  end

  // 2*sum + n over 2*n, rounded half up
  always_ff @(posedge clk) begin
    x    <= SUM_X_W'({sum, 1'b0}) + SUM_X_W'(ctl.cnt);
    rcp  <= recip(ctl.cnt);
    mean <= prod[RECIP_SHIFT +: CH_W];
  end

  assign prod = PROD_W'(x) * PROD_W'(rcp);

endmodule

[src/box_blur_3x3_clipped_top.sv]
// Top level of the 3x3 clipped box blur over a raster RGB stream.
//
//  channel | dir | tdata / data                      | side bits
//  s_*     | in  | [7:0] red [15:8] green [23:16] blue | tuser: command (1 = drain)
//  m_*     | out | [7:0] red [15:8] green [23:16] blue | tlast: last of run, tuser: frame done
//  APB     | in  | 0x0 img_width, 0x4 img_height       | pready tied high
//
// A pixel beat passes the pixel state and, per result, the go, wait, capture
// and output states around the lane pipeline (sum, multiply); a drain beat first
// reads three columns through the one read port of each line store. Output
// stalls hold the block in its output state. Reset is synchronous: width
// 1024, height 1, counters and drain cleared; line stores are not cleared.
module box_blur_3x3_clipped_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red, green, blue from bit 0 up
  input  logic        s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_red, out_green, out_blue from bit 0 up
  output logic        m_tlast,
  output logic        m_tuser,   // frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bb3_pkg::*;

  state_t state, state_next;

  logic [WCFG_W-1:0] img_width;
  logic [HCFG_W-1:0] img_height;
  logic [WCFG_W-1:0] eff_w;
  logic [HCFG_W-1:0] eff_h;

  logic [ROW_W-1:0]  row_count;
  logic [ADDR_W-1:0] col_count;
  logic [ADDR_W-1:0] dcol;
  logic              drain_pending;

  logic [PIX_W-1:0]            pix_hold;
  logic [NWIN-1:0][PIX_W-1:0]  win;
  logic [2:0]                  rm, cm_a, cm_b;
  logic                        has_b, sel, is_drain, done_flag;

  logic                 s_acc, cfg_wr;
  logic [ADDR_W-1:0]    raddr;
  logic                 ram_we;
  logic [PIX_W-1:0]     old_q, new_q;
  logic                 pix_emits;
  logic [WCFG_W-1:0]    col_ext;
  logic [WCFG_W-1:0]    col_inc, dcol_inc;
  logic [HCFG_W-1:0]    row_inc;
  logic [2:0]           cm;
  lane_ctl_t            lctl;
  lane_win_t [NCH-1:0]  lwin;
  logic [NCH-1:0][CH_W-1:0] lmean;

  assign s_acc  = s_tvalid && s_tready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_HEIGHT) ? 32'(img_height) : 32'(img_width);

  // clamp the register values into their legal ranges
  always_comb begin
    eff_w = img_width;
    if (img_width == '0) eff_w = WCFG_W'(1);
    else if (img_width > WCFG_W'(MAX_WIDTH)) eff_w = WCFG_W'(MAX_WIDTH);
    eff_h = img_height;
    if (img_height == '0) eff_h = HCFG_W'(1);
    else if (img_height > HCFG_W'(MAX_HEIGHT)) eff_h = HCFG_W'(MAX_HEIGHT);
  end

  assign col_ext  = WCFG_W'(col_count);
  assign col_inc  = col_ext + WCFG_W'(1);
  assign dcol_inc = WCFG_W'(dcol) + WCFG_W'(1);
  assign row_inc  = HCFG_W'(row_count) + HCFG_W'(1);
  assign pix_emits = (row_count != '0) &&
                     ((col_count != '0) || (col_ext == eff_w - WCFG_W'(1)));

  // read address: the pixel column, or the three drain columns in turn
  always_comb begin
    case (state)
      ST_IDLE: raddr = drain_pending ? dcol - ADDR_W'(1) : col_count;
      ST_DR1:  raddr = dcol;
      ST_DR2:  raddr = dcol + ADDR_W'(1);
      default: raddr = col_count;
    endcase
  end

  assign ram_we = (state == ST_PIX);

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(ram_we), .waddr(col_count), .wdata(new_q),
    .raddr(raddr), .rdata(old_q)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk(clk), .we(ram_we), .waddr(col_count), .wdata(pix_hold),
    .raddr(raddr), .rdata(new_q)
  );

  // mask from row and column selects; count of neighbors in frame
  always_comb begin
    cm = sel ? cm_b : cm_a;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lctl.mask[r*3+c] = rm[r] & cm[c];
      end
    end
    lctl.cnt = CNT_W'($countones(lctl.mask));
    for (int k = 0; k < NCH; k++) begin
      for (int e = 0; e < NWIN; e++) begin
        lwin[k][e] = win[e][k*CH_W +: CH_W];
      end
    end
  end

  for (genvar k = 0; k < NCH; k++) begin : g_lane
    bb3_lane u_lane (.clk(clk), .win(lwin[k]), .ctl(lctl), .mean(lmean[k]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_acc) begin
          if (drain_pending) state_next = ST_DR1;
          else if (!s_tuser) state_next = ST_PIX;
        end
      end
      ST_PIX:  state_next = pix_emits ? ST_GO : ST_IDLE;
      ST_DR1:  state_next = ST_DR2;
      ST_DR2:  state_next = ST_DR3;
      ST_DR3:  state_next = ST_GO;
      ST_GO:   state_next = ST_WAIT;
      ST_WAIT: state_next = ST_CAP;
      ST_CAP:  state_next = ST_OUT;
      ST_OUT: begin
        if (m_tready) state_next = (!sel && has_b) ? ST_GO : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers: counters, drain, output valid, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= '0;
      col_count     <= '0;
      dcol          <= '0;
      drain_pending <= 1'b0;
      m_tvalid      <= 1'b0;
      img_width     <= WCFG_W'(MAX_WIDTH);
      img_height    <= HCFG_W'(1);
    end else begin
      case (state)
        ST_PIX: begin
          if (col_inc >= eff_w) begin
            col_count <= '0;
            if (row_inc >= eff_h) begin
              row_count     <= '0;
              drain_pending <= 1'b1;
              dcol          <= '0;
            end else begin
              row_count <= row_count + ROW_W'(1);
            end
          end else begin
            col_count <= col_count + ADDR_W'(1);
          end
        end
        ST_DR3: begin
          if (dcol_inc >= eff_w) begin
            drain_pending <= 1'b0;
            dcol          <= '0;
          end else begin
            dcol <= dcol + ADDR_W'(1);
          end
        end
        ST_CAP: m_tvalid <= 1'b1;
        ST_OUT: if (m_tready) m_tvalid <= 1'b0;
        default: ;
      endcase
      // a register write restarts the frame
      if (cfg_wr) begin
        if (paddr[2] == CFG_WIDTH) img_width <= pwdata[WCFG_W-1:0];
        else img_height <= pwdata[HCFG_W-1:0];
        row_count     <= '0;
        col_count     <= '0;
        dcol          <= '0;
        drain_pending <= 1'b0;
      end
    end
  end

  // payload: window, result plan, output beat
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_acc) begin
          pix_hold <= s_tdata;
          is_drain <= drain_pending;
        end
      end
      ST_PIX: begin
        // shift left, bring in the new column of rows i-2, i-1, i
        win[0] <= win[1]; win[1] <= win[2]; win[2] <= old_q;
        win[3] <= win[4]; win[4] <= win[5]; win[5] <= new_q;
        win[6] <= win[7]; win[7] <= win[8]; win[8] <= pix_hold;
        rm        <= {2'b11, row_count >= ROW_W'(2)};
        cm_a      <= {2'b11, col_count >= ADDR_W'(2)};
        cm_b      <= {1'b1, eff_w >= WCFG_W'(2), 1'b0};
        has_b     <= (row_count != '0) && (col_ext == eff_w - WCFG_W'(1));
        sel       <= (col_count == '0);
        done_flag <= 1'b0;
      end
      ST_DR1: begin
        win[0] <= old_q; win[3] <= new_q;
      end
      ST_DR2: begin
        win[1] <= old_q; win[4] <= new_q;
      end
      ST_DR3: begin
        win[2]    <= old_q; win[5] <= new_q;
        rm        <= {1'b0, 1'b1, eff_h >= HCFG_W'(2)};
        cm_a      <= {dcol_inc < eff_w, 1'b1, dcol != '0};
        has_b     <= 1'b0;
        sel       <= 1'b0;
        done_flag <= (dcol_inc >= eff_w);
      end
      ST_CAP: begin
        // merge the three lanes into one beat
        m_tdata <= {lmean[2], lmean[1], lmean[0]};
        m_tlast <= is_drain || sel || !has_b;
        m_tuser <= done_flag;
      end
      ST_OUT: begin
        if (m_tready && !sel && has_b) sel <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

[src/bb3_chk.sv]
// Port-level checker for the blur top level, bound to it below.
`include "assert_macros.svh"

module bb3_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  `BB3_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid)
  `BB3_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata))
  `BB3_ASSERT(a_done_is_last, m_tvalid && m_tuser |-> m_tlast)
  `BB3_ASSERT(a_no_take_while_out, m_tvalid |-> !s_tready)
  `BB3_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid)

endmodule

bind box_blur_3x3_clipped_top bb3_chk u_bb3_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
);

[sim/tb.sv]
// Self-checking bench for the 3x3 clipped box blur: random frames, drains and noise.
`timescale 1ns / 100ps

module tb;
  import bb3_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int END_SETTLE     = 40;

  typedef struct packed {
    logic       cmd;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
    logic       done;
  } blur_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_blur_3x3_clipped_top dut (.*);

  always #5 clk = ~clk;

  // Predictor state: line stores, window, position and drain tracking
  logic [23:0] row_older [MAX_WIDTH];
  logic [23:0] row_newer [MAX_WIDTH];
  logic [23:0] win [9];
  int unsigned cur_row, cur_col, drain_pos;
  bit          draining;
  int unsigned cfg_w = 1024, cfg_h = 1;

  pixel_beat_t pending_beats[$];
  blur_out_t   expected_pixels[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic        in_acc_q = 1'b0;

  function automatic blur_out_t average_window(logic [23:0] w [9], int rmask, int cmask,
                                               bit done);
    int unsigned sr, sg, sb, n;
    blur_out_t o;
    sr = 0; sg = 0; sb = 0; n = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (rmask[r] && cmask[c]) begin
          sr += w[r*3+c][23:16]; sg += w[r*3+c][15:8]; sb += w[r*3+c][7:0]; n++;
        end
    if (n == 0) n = 1;
    o.r = 8'((2*sr + n) / (2*n));
    o.g = 8'((2*sg + n) / (2*n));
    o.b = 8'((2*sb + n) / (2*n));
    o.last = 1'b0;
    o.done = done;
    return o;
  endfunction

  // Advance the predictor by one accepted beat, queuing the pixels it releases
  task automatic predict_blur(pixel_beat_t it);
    logic [23:0] t [9];
    logic [23:0] px;
    blur_out_t   o;
    int unsigned c, j, cm, rm, n;
    bit          done;
    px = {it.r, it.g, it.b};
    if (it.cmd || draining) begin
      if (!draining) return;
      c = drain_pos;
      if (c >= cfg_w) begin draining = 0; drain_pos = 0; return; end
      foreach (t[k]) t[k] = '0;
      cm = 2 | (c >= 1 ? 1 : 0) | (c + 1 < cfg_w ? 4 : 0);
      if (c >= 1) begin t[0] = row_older[c-1]; t[3] = row_newer[c-1]; end
      t[1] = row_older[c]; t[4] = row_newer[c];
      if (c + 1 < cfg_w) begin t[2] = row_older[c+1]; t[5] = row_newer[c+1]; end
      done = (c + 1 >= cfg_w);
      o = average_window(t, 2 | (cfg_h >= 2 ? 1 : 0), cm, done);
      o.last = 1'b1;
      expected_pixels.push_back(o);
      if (done) begin draining = 0; drain_pos = 0; end
      else drain_pos = c + 1;
      return;
    end
    j = (cur_col >= cfg_w) ? cfg_w - 1 : cur_col;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1]; win[r*3+1] = win[r*3+2];
    end
    win[2] = row_older[j]; win[5] = row_newer[j]; win[8] = px;
    row_older[j] = row_newer[j]; row_newer[j] = px;
    if (cur_row >= 1) begin
      n = 0;
      rm = 6 | (cur_row >= 2 ? 1 : 0);
      if (j >= 1) begin
        expected_pixels.push_back(average_window(win, rm, 6 | (j >= 2 ? 1 : 0), 0)); n++;
      end
      if (j == cfg_w - 1) begin
        expected_pixels.push_back(average_window(win, rm, 4 | (cfg_w >= 2 ? 2 : 0), 0)); n++;
      end
      if (n > 0) expected_pixels[$].last = 1'b1;
    end
    cur_col = j + 1;
    if (cur_col >= cfg_w) begin
      cur_col = 0; cur_row++;
      if (cur_row >= cfg_h) begin cur_row = 0; draining = 1; drain_pos = 0; end
    end
  endtask

  // Register write over APB: setup then access, driven on falling edges
  task automatic write_register(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    // Raw value goes into the register; the block clamps it
    if (addr == 3'd0) cfg_w = value[10:0];
    else cfg_h = value[12:0];
    if (cfg_w < 1) cfg_w = 1;
    if (cfg_w > MAX_WIDTH) cfg_w = MAX_WIDTH;
    if (cfg_h < 1) cfg_h = 1;
    if (cfg_h > MAX_HEIGHT) cfg_h = MAX_HEIGHT;
    cur_row = 0; cur_col = 0; drain_pos = 0; draining = 0;
  endtask

  // Hold until every queued beat went in and every expected pixel came out
  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
  endtask

  function automatic pixel_beat_t random_pixel();
    pixel_beat_t p;
    p.cmd = 0;
    p.r = 8'($urandom); p.g = 8'($urandom); p.b = 8'($urandom);
    return p;
  endfunction

  // Whole frame plus enough drain beats; optionally drop noise into it
  task automatic queue_frame(bit noisy);
    pixel_beat_t p;
    for (int k = 0; k < cfg_w * cfg_h; k++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        p = random_pixel(); p.cmd = 1; pending_beats.push_back(p);
      end
      pending_beats.push_back(random_pixel());
    end
    for (int k = 0; k < cfg_w + (noisy ? $urandom_range(0, 2) : 0); k++) begin
      p = random_pixel();
      // a pixel during a drain acts as a drain step
      p.cmd = noisy ? 1'($urandom_range(0, 1)) : 1'b1;
      pending_beats.push_back(p);
    end
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, bit noisy);
    write_register(3'd0, w);
    write_register(3'd4, h);
    queue_frame(noisy);
    wait_idle();
  endtask

  // Driver: bursts of random length separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else if (s_tvalid && !in_acc_q) begin
      // hold the presented beat until it is accepted
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      s_tvalid <= 0;
    end else if (pending_beats.size() > 0) begin
      automatic pixel_beat_t nb = pending_beats[0];
      s_tvalid <= 1;
      s_tuser  <= nb.cmd;
      s_tdata  <= {nb.b, nb.g, nb.r};
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_tvalid <= 0;
    end
  end

  // Receiver stall pattern: long ready stretches, then short random stalls
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 64;
    if (rst) m_tready <= 0;
    else if (stall_phase < 24) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 2) != 0);
  end

  // Monitor: predict on input beats, compare on output beats
  always @(posedge clk) begin
    if (!rst) begin
      in_acc_q <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        predict_blur(pixel_beat_t'({s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}));
        void'(pending_beats.pop_front());
      end
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h", m_tdata);
        end else begin
          automatic blur_out_t e = expected_pixels.pop_front();
          automatic blur_out_t a = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                                    m_tlast, m_tuser};
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp r%0d g%0d b%0d l%0b d%0b got r%0d g%0d b%0d l%0b d%0b",
                       e.r, e.g, e.b, e.last, e.done, a.r, a.g, a.b, a.last, a.done);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    pixel_beat_t p;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // Drain with nothing pending is ignored
    p = random_pixel(); p.cmd = 1; pending_beats.push_back(p);
    wait_idle();
    // Extreme pixel values over a 3x3 frame, interior plus all corners
    write_register(3'd0, 3);
    write_register(3'd4, 3);
    for (int k = 0; k < 9; k++) begin
      p.cmd = 0;
      p.r = (k % 2) ? 8'hFF : 8'h00; p.g = (k % 3) ? 8'h00 : 8'hFF; p.b = 8'(8'hAA ^ k);
      pending_beats.push_back(p);
    end
    for (int k = 0; k < 3; k++) begin p.cmd = 1; pending_beats.push_back(p); end
    wait_idle();
    run_frame(1, 1, 0);
    run_frame(1, 4, 0);
    run_frame(5, 1, 0);
    // Out-of-range registers saturate
    run_frame(0, 0, 0);
    // Oversized registers: start a frame, the next register write restarts it
    write_register(3'd0, 2047);
    write_register(3'd4, 8191);
    for (int k = 0; k < 20; k++) pending_beats.push_back(random_pixel());
    wait_idle();
    // Random frames with random sizes
    for (int f = 0; f < 19; f++)
      run_frame($urandom_range(1, 16), $urandom_range(1, 8), 1'($urandom_range(0, 1)));
    wait_idle();
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/bb3_pkg.sv
src/bb3_ram.sv
src/bb3_lane.sv
src/box_blur_3x3_clipped_top.sv
src/bb3_chk.sv
sim/tb.sv
